### hdl/at_path_mention_scanner_defines.svh
// Assertion macros shared by the mention scanner RTL.
`ifndef AT_PATH_MENTION_SCANNER_DEFINES_SVH
`define AT_PATH_MENTION_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ATPM_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ATPM_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/atpm_pkg.sv
// Shared constants, types and helpers for the mention scanner.
package atpm_pkg;

  localparam int POSITION_BITS = 16;
  localparam int OUT_BITS      = 16;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI  = 8'h39;
  localparam logic [7:0] CH_UPPER_LO  = 8'h41;
  localparam logic [7:0] CH_UPPER_HI  = 8'h5A;
  localparam logic [7:0] CH_LOWER_LO  = 8'h61;
  localparam logic [7:0] CH_LOWER_HI  = 8'h7A;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OUT_BITS-1:0]      out_pos_t;

  // Classes of one text byte.
  typedef struct packed {
    logic is_path;
    logic is_dot;
    logic is_at;
    logic may_precede;
  } byte_class_t;

  // One scan step's result.
  typedef struct packed {
    logic     emit;
    out_pos_t start;
    out_pos_t stop;
  } scan_result_t;

  // Low OUT_BITS of a position, zero-extended when positions are narrower.
  function automatic out_pos_t to_out(pos_t v);
    logic [POSITION_BITS+OUT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, v};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

### hdl/at_path_mention_scanner.sv
// Top level of the at-sign path mention scanner.
`include "at_path_mention_scanner_defines.svh"

// Streams text one byte per transaction and reports "@path" mentions as
// (mention_start, mention_end) byte offsets, mention_end exclusive with
// trailing dots trimmed. A text ends with the byte that carries end_of_text;
// all scan state but the stored run offsets clears after it. Each byte lands
// in an input register; when it advances, it is classified and folded into
// the scan state and any mention it closes goes to the output register. One
// byte per cycle is sustained while the output side does not stall. Offsets
// saturate at 65535.
module at_path_mention_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] mention_start,
  output logic [15:0] mention_end
);

  // Input register.
  logic       r_valid;
  logic [7:0] r_byte;
  logic       r_last;

  atpm_pkg::byte_class_t  cls;
  atpm_pkg::scan_result_t result;

  logic in_take;
  logic out_free;
  logic go;

  atpm_classify u_classify (
    .text_byte (r_byte),
    .cls       (cls)
  );

  atpm_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .last   (r_last),
    .cls    (cls),
    .result (result)
  );

  // Advance the held byte when the output slot can take its result, or when
  // it produces none.
  always_comb begin
    out_free = !out_valid || !out_stall;
    go       = r_valid && (out_free || !result.emit);
    in_stall = r_valid && !go;
    in_take  = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (in_take) begin
      r_valid <= 1'b1;
    end else if (go) begin
      r_valid <= 1'b0;
    end
  end

  // Hold the payload of a byte until it is scanned.
  always_ff @(posedge clk) begin
    if (in_take) begin
      r_byte <= text_byte;
      r_last <= end_of_text;
    end
  end

  // Output register: load a new mention, drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && result.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && result.emit) begin
      mention_start <= result.start;
      mention_end   <= result.stop;
    end
  end

  `ATPM_ASSERT_NOW(a_stall_needs_byte, clk, rst, in_stall, r_valid, "input stalled with no byte held")
  `ATPM_ASSERT_NOW(a_no_overwrite, clk, rst, go && result.emit, out_free, "pending mention overwritten")
  `ATPM_ASSERT_NEXT(a_emit_shows, clk, rst, go && result.emit, out_valid, "emitted mention not presented")

endmodule

### hdl/atpm_classify.sv
// Byte classifier: path byte, dot, at sign, and may-precede-at flags.
module atpm_classify (
  input  logic [7:0]           text_byte,
  output atpm_pkg::byte_class_t cls
);

  logic is_alnum;
  logic is_punct;

  always_comb begin
    is_alnum = text_byte inside {[atpm_pkg::CH_DIGIT_LO:atpm_pkg::CH_DIGIT_HI],
                                 [atpm_pkg::CH_UPPER_LO:atpm_pkg::CH_UPPER_HI],
                                 [atpm_pkg::CH_LOWER_LO:atpm_pkg::CH_LOWER_HI]};
    is_punct = text_byte inside {atpm_pkg::CH_SLASH, atpm_pkg::CH_BACKSLASH,
                                 atpm_pkg::CH_DOT, atpm_pkg::CH_UNDERLINE,
                                 atpm_pkg::CH_DASH, atpm_pkg::CH_PLUS,
                                 atpm_pkg::CH_TILDE, atpm_pkg::CH_HASH};
    cls.is_path     = is_alnum | is_punct;
    cls.is_dot      = (text_byte == atpm_pkg::CH_DOT);
    cls.is_at       = (text_byte == atpm_pkg::CH_AT);
    cls.may_precede = !is_alnum &&
                      !(text_byte inside {atpm_pkg::CH_DOT, atpm_pkg::CH_UNDERLINE,
                                          atpm_pkg::CH_DASH});
  end

endmodule

### hdl/atpm_scan.sv
// Scan state: position counter, open-path tracking and result forming.
`include "at_path_mention_scanner_defines.svh"

module atpm_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic                   last,
  input  atpm_pkg::byte_class_t  cls,
  output atpm_pkg::scan_result_t result
);

  atpm_pkg::pos_t byte_position;
  atpm_pkg::pos_t at_sign_position;
  atpm_pkg::pos_t trimmed_end;
  logic           seen_any_byte;
  logic           prev_may_precede;
  logic           inside_path;
  logic           has_non_dot;

  atpm_pkg::pos_t pos_next;
  atpm_pkg::pos_t end_value;
  logic           still_inside;
  logic           open_run;
  logic           adds_non_dot;

  always_comb begin
    pos_next     = (byte_position == atpm_pkg::POS_MAX) ? byte_position
                                                        : byte_position + atpm_pkg::pos_t'(1);
    still_inside = inside_path && cls.is_path;
    adds_non_dot = still_inside && !cls.is_dot;
    open_run     = !still_inside && cls.is_at && (!seen_any_byte || prev_may_precede);
    end_value    = adds_non_dot ? pos_next : trimmed_end;
    // Emit on a byte that closes a run holding a non-dot, or on the text's final byte while such a run is open.
    result.emit  = inside_path &&
                   (cls.is_path ? (last && (has_non_dot || adds_non_dot)) : has_non_dot);
    result.start = atpm_pkg::to_out(at_sign_position);
    result.stop  = atpm_pkg::to_out(end_value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      seen_any_byte    <= 1'b0;
      prev_may_precede <= 1'b0;
      inside_path      <= 1'b0;
      has_non_dot      <= 1'b0;
    end else if (go) begin
      if (last) begin
        byte_position    <= '0;
        seen_any_byte    <= 1'b0;
        prev_may_precede <= 1'b0;
        inside_path      <= 1'b0;
        has_non_dot      <= 1'b0;
      end else begin
        byte_position    <= pos_next;
        seen_any_byte    <= 1'b1;
        prev_may_precede <= cls.may_precede;
        inside_path      <= still_inside || open_run;
        if (open_run) begin
          has_non_dot <= 1'b0;
        end else if (adds_non_dot) begin
          has_non_dot <= 1'b1;
        end else if (!still_inside) begin
          has_non_dot <= 1'b0;
        end
      end
    end
  end

  // Offsets of the open run; read only while a run is open.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_sign_position <= '0;
      trimmed_end      <= '0;
    end else if (go && !last) begin
      if (open_run) begin
        at_sign_position <= byte_position;
        trimmed_end      <= pos_next;
      end else if (adds_non_dot) begin
        trimmed_end <= pos_next;
      end
    end
  end

  `ATPM_ASSERT_NEXT(a_last_clears, clk, rst, go && last, !inside_path && !seen_any_byte && (byte_position == '0), "state not cleared after final byte")
  `ATPM_ASSERT_NOW(a_run_after_byte, clk, rst, inside_path, seen_any_byte, "path run open before any byte")
  `ATPM_ASSERT_NOW(a_end_past_start, clk, rst, go && result.emit, (end_value > at_sign_position) || (at_sign_position == atpm_pkg::POS_MAX), "mention end not past its start")

endmodule
